// File: hw/rtl/u8r_pkg.sv
// Shared types and constants for the UTF-8 maximal-subpart repair block.
`default_nettype none
package u8r_pkg;

  // Replacement character U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Most result bytes that one input byte can cause
  localparam int MAX_RESULTS = 6;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef logic [7:0]           byte_t;
  typedef logic [RES_CNT_W-1:0] res_cnt_t;
  typedef logic [1:0]           pend_cnt_t;

  // Classification of a byte seen in lead position
  typedef enum logic [1:0] {
    LEAD_ASCII = 2'b00,
    LEAD_START = 2'b01,
    LEAD_BAD   = 2'b10
  } lead_kind_t;

  function automatic lead_kind_t lead_kind(input byte_t b);
    lead_kind_t k;
    if (!b[7]) begin
      k = LEAD_ASCII;
    end else if ((b >= 8'hC2) && (b <= 8'hF4)) begin
      k = LEAD_START;
    end else begin
      k = LEAD_BAD;
    end
    return k;
  endfunction

  // Full sequence length for a valid lead: 2, 3 or 4
  function automatic logic [2:0] seq_len(input byte_t lead);
    logic [2:0] len;
    if (lead[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (lead[7:4] == 4'hE) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/utf8_repair_maximal_subpart.sv
// Top level of the UTF-8 repair block with maximal-subpart replacement.
//
// Bytes of a string enter one per transaction on the input channel, string_last
// marking the final byte. Well-formed UTF-8 passes through unchanged; each
// maximal ill-formed subpart, a surrogate, or a sequence cut short by the end
// of the string leaves as one EF BF BD. Each input byte causes zero to six
// output bytes; run_last marks the last of them and string_end the last byte
// of the string. An input register holds one byte while the six-byte result
// shift register drains; the decode between them is combinational. Plain
// text, at most one result per byte, flows at one byte per cycle while
// out_ready is high; a byte with k results holds the input until the result
// shift register has sent them all, one byte per cycle while out_ready is high.
`default_nettype none
module utf8_repair_maximal_subpart (
  input  wire                  clk,
  input  wire                  rst,
  input  wire u8r_pkg::byte_t  in_byte,
  input  wire                  string_last,
  input  wire                  in_valid,
  output logic                 in_ready,
  output u8r_pkg::byte_t       out_byte,
  output logic                 run_last,
  output logic                 string_end,
  output logic                 out_valid,
  input  wire                  out_ready
);
  import u8r_pkg::*;

  // Input register
  logic  hold_valid;
  byte_t hold_byte;
  logic  hold_last;

  // Held prefix of a sequence in progress
  byte_t     pend [3];
  pend_cnt_t pend_count;
  pend_cnt_t pend_count_next;
  logic      wr_lead;
  logic      wr_mid;

  // Result shift register
  byte_t    res_buf [MAX_RESULTS];
  res_cnt_t res_rem;
  logic     res_last;

  // Decode outputs
  byte_t      res [MAX_RESULTS];
  res_cnt_t   res_n;
  lead_kind_t kind;
  logic [2:0] len;
  logic [2:0] cnt_ext;
  logic       accepts;
  logic       load;

  assign kind    = lead_kind(hold_byte);
  assign len     = seq_len(pend[0]);
  assign cnt_ext = {1'b0, pend_count};

  // Check the next byte against the held lead
  always_comb begin
    accepts = (hold_byte[7:6] == 2'b10);
    if (pend_count == 2'd1) begin
      if (pend[0] == 8'hE0) begin
        accepts = accepts && (hold_byte >= 8'hA0);
      end else if (pend[0] == 8'hF0) begin
        accepts = accepts && (hold_byte >= 8'h90);
      end else if (pend[0] == 8'hF4) begin
        accepts = accepts && (hold_byte <= 8'h8F);
      end
    end
  end

  // Decode one byte into its result bytes and the next prefix state
  always_comb begin
    res[0] = REPL_B0;
    res[1] = REPL_B1;
    res[2] = REPL_B2;
    res[3] = REPL_B0;
    res[4] = REPL_B1;
    res[5] = REPL_B2;
    res_n           = '0;
    pend_count_next = pend_count;
    wr_lead         = 1'b0;
    wr_mid          = 1'b0;
    if (pend_count == 2'd0) begin
      // Plain lead position
      unique case (kind)
        LEAD_ASCII: begin
          res[0] = hold_byte;
          res_n  = res_cnt_t'(1);
        end
        LEAD_START: begin
          wr_lead         = 1'b1;
          pend_count_next = hold_last ? 2'd0 : 2'd1;
          res_n           = hold_last ? res_cnt_t'(3) : res_cnt_t'(0);
        end
        default: begin
          res_n = res_cnt_t'(3);
        end
      endcase
    end else if ((cnt_ext >= len) || !accepts) begin
      // Broken prefix: replace it, then treat the byte as a new lead
      pend_count_next = 2'd0;
      unique case (kind)
        LEAD_ASCII: begin
          res[3] = hold_byte;
          res_n  = res_cnt_t'(4);
        end
        LEAD_START: begin
          wr_lead         = 1'b1;
          pend_count_next = hold_last ? 2'd0 : 2'd1;
          res_n           = hold_last ? res_cnt_t'(6) : res_cnt_t'(3);
        end
        default: begin
          res_n = res_cnt_t'(6);
        end
      endcase
    end else if ((cnt_ext + 3'd1) < len) begin
      // Extend the prefix; cut it off at the end of the string
      wr_mid          = 1'b1;
      pend_count_next = hold_last ? 2'd0 : (pend_count + 2'd1);
      res_n           = hold_last ? res_cnt_t'(3) : res_cnt_t'(0);
    end else begin
      // Sequence complete
      pend_count_next = 2'd0;
      if ((pend[0] == 8'hED) && (pend[1] >= 8'hA0)) begin
        res_n = res_cnt_t'(3);
      end else begin
        res[0] = pend[0];
        res[1] = (pend_count == 2'd1) ? hold_byte : pend[1];
        res[2] = (pend_count == 2'd2) ? hold_byte : pend[2];
        res[3] = hold_byte;
        res_n  = res_cnt_t'(cnt_ext + 3'd1);
      end
    end
  end

  // Move the held byte into the result register once it frees up
  assign load     = hold_valid && ((res_rem == '0) || ((res_rem == res_cnt_t'(1)) && out_ready));
  assign in_ready = !hold_valid || load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= (in_valid && in_ready) || (hold_valid && !load);
    end
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
      hold_last <= string_last;
    end
  end

  // Prefix state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 2'd0;
    end else if (load) begin
      pend_count <= pend_count_next;
    end
    if (load && wr_lead) begin
      pend[0] <= hold_byte;
    end
    if (load && wr_mid) begin
      pend[pend_count] <= hold_byte;
    end
  end

  // Result shift register: load a new run or shift out one byte
  always_ff @(posedge clk) begin
    if (rst) begin
      res_rem <= '0;
    end else if (load) begin
      res_rem <= res_n;
    end else if (out_valid && out_ready) begin
      res_rem <= res_rem - res_cnt_t'(1);
    end
    if (load) begin
      res_buf  <= res;
      res_last <= hold_last;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_buf[i] <= res_buf[i+1];
      end
    end
  end

  assign out_valid  = (res_rem != '0);
  assign out_byte   = res_buf[0];
  assign run_last   = (res_rem == res_cnt_t'(1));
  assign string_end = run_last && res_last;

endmodule
`default_nettype wire

// File: hw/rtl/u8r_checker.sv
// Port-level assertions for the UTF-8 repair block, bound to its top level.
`default_nettype none
module u8r_checker (
  input wire       clk,
  input wire       rst,
  input wire [7:0] out_byte,
  input wire       run_last,
  input wire       string_end,
  input wire       out_valid,
  input wire       out_ready
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(run_last) && $stable(string_end))
    else $error("stalled output transaction changed");

  // End of string only on the last byte of a run
  a_end_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string_end without run_last");

  // A run drains without gaps
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside a result run");

  // Reset leaves the output empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_repair_maximal_subpart u8r_checker u_u8r_checker (
  .clk        (clk),
  .rst        (rst),
  .out_byte   (out_byte),
  .run_last   (run_last),
  .string_end (string_end),
  .out_valid  (out_valid),
  .out_ready  (out_ready)
);
`default_nettype wire

// File: test/utf8_checker.sv
// Checker for the UTF-8 repair block: predicts the repaired byte stream and compares results.
`default_nettype none
module utf8_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire u8r_pkg::byte_t in_byte,
  input  wire                 string_last,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  wire u8r_pkg::byte_t out_byte,
  input  wire                 run_last,
  input  wire                 string_end,
  input  wire                 out_valid,
  input  wire                 out_ready,
  output int                  fail_count,
  output int                  backlog
);
  timeunit 1ns;
  timeprecision 1ps;
  import u8r_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  str_end;
  } out_rec_t;

  localparam int REPORT_MAX = 10;

  // Expected output bytes, oldest first, and the results of the byte being decoded
  out_rec_t repaired_q[$];
  out_rec_t step_q[$];

  // Valid prefix held so far
  byte_t      held [3];
  logic [1:0] held_n;

  int errs;

  initial begin
    fail_count = 0;
    backlog    = 0;
    errs       = 0;
    held_n     = 2'd0;
  end

  task automatic put(input byte_t b);
    step_q.push_back('{data: b, run_last: 1'b0, str_end: 1'b0});
  endtask

  task automatic put_repl();
    put(REPL_B0);
    put(REPL_B1);
    put(REPL_B2);
  endtask

  function automatic bit is_cont(input byte_t b);
    return b[7:6] == 2'b10;
  endfunction

  // Length of the whole sequence that a valid lead opens
  function automatic int unsigned lead_len(input byte_t lead);
    if (lead <= 8'hDF) return 2;
    if (lead <= 8'hEF) return 3;
    return 4;
  endfunction

  // Second-byte limits after E0, F0 and F4; every other position takes 80..BF
  function automatic bit fits(input byte_t lead, input int unsigned cnt, input byte_t b);
    if (!is_cont(b)) return 1'b0;
    if (cnt == 1) begin
      if (lead == 8'hE0) return b >= 8'hA0;
      if (lead == 8'hF0) return b >= 8'h90;
      if (lead == 8'hF4) return b <= 8'h8F;
    end
    return 1'b1;
  endfunction

  task automatic start_lead(input byte_t b);
    if (b < 8'h80) begin
      put(b);
    end else if (b >= 8'hC2 && b <= 8'hF4) begin
      held[0] = b;
      held_n  = 2'd1;
    end else begin
      put_repl();
    end
  endtask

  // Decode one accepted byte and queue the output bytes it causes
  task automatic repair_byte(input byte_t b, input logic last);
    int unsigned cnt;
    int unsigned len;
    byte_t       lead;
    out_rec_t    r;
    step_q.delete();
    cnt = held_n;
    if (cnt == 0) begin
      start_lead(b);
    end else begin
      lead = held[0];
      len  = lead_len(lead);
      if (cnt >= len || !fits(lead, cnt, b)) begin
        // Broken prefix: replace it, then treat the breaking byte as a lead
        held_n = 2'd0;
        put_repl();
        start_lead(b);
      end else if (cnt + 1 < len) begin
        held[cnt] = b;
        held_n    = 2'(cnt + 1);
      end else begin
        held_n = 2'd0;
        if (len == 3 && lead == 8'hED && held[1] >= 8'hA0) begin
          // Surrogate code point: one replacement for all three bytes
          put_repl();
        end else begin
          for (int i = 0; i < cnt; i++) put(held[i]);
          put(b);
        end
      end
    end
    // Truncated prefix at the end of the string
    if (last && held_n != 0) begin
      held_n = 2'd0;
      put_repl();
    end
    if (step_q.size() > 0) begin
      r = step_q[step_q.size() - 1];
      r.run_last = 1'b1;
      r.str_end  = last;
      step_q[step_q.size() - 1] = r;
    end
    foreach (step_q[i]) repaired_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    out_rec_t got;
    out_rec_t want;
    if (rst) begin
      repaired_q.delete();
      held_n = 2'd0;
    end else begin
      // Predict first so a same-cycle result still finds its expectation
      if (in_valid && in_ready) repair_byte(in_byte, string_last);
      if (out_valid && out_ready) begin
        got = '{data: out_byte, run_last: run_last, str_end: string_end};
        if (repaired_q.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX)
            $display("unexpected output: byte %02h run_last %0b string_end %0b",
                     got.data, got.run_last, got.str_end);
        end else begin
          want = repaired_q.pop_front();
          if (got != want) begin
            errs++;
            if (errs <= REPORT_MAX)
              $display("mismatch: expected byte %02h run_last %0b string_end %0b, got %02h %0b %0b",
                       want.data, want.run_last, want.str_end,
                       got.data, got.run_last, got.str_end);
          end
        end
      end
    end
    fail_count <= errs;
    backlog    <= repaired_q.size();
  end

endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench top for the UTF-8 repair block: drives byte strings and gives the verdict.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8r_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_ITEMS  = 360;
  localparam int DRAIN_TICKS = 20;

  typedef enum int unsigned {
    UNIT_ASCII,
    UNIT_MULTI,
    UNIT_SURROGATE,
    UNIT_BROKEN,
    UNIT_NOISE
  } unit_kind_t;

  logic  clk         = 1'b0;
  logic  rst         = 1'b1;
  byte_t in_byte     = 8'h00;
  logic  string_last = 1'b0;
  logic  in_valid    = 1'b0;
  logic  out_ready   = 1'b0;
  logic  in_ready;
  byte_t out_byte;
  logic  run_last;
  logic  string_end;
  logic  out_valid;

  int fail_count;
  int backlog;
  int idle_cycles = 0;
  bit quiet       = 1'b0;

  // Bytes of the string being built
  byte_t str_bytes[$];

  utf8_repair_maximal_subpart dut (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .string_last(string_last),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  utf8_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .string_last(string_last),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the output side at random
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one byte after a random gap and hold it until the transaction
  task automatic send_byte(input byte_t b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    string_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Encode a code point; returns the sequence length
  function automatic int encode_cp(input bit [20:0] c, output byte_t s [4]);
    if (c < 21'h800) begin
      s[0] = {3'b110, c[10:6]};
      s[1] = {2'b10, c[5:0]};
      return 2;
    end
    if (c < 21'h10000) begin
      s[0] = {4'b1110, c[15:12]};
      s[1] = {2'b10, c[11:6]};
      s[2] = {2'b10, c[5:0]};
      return 3;
    end
    s[0] = {5'b11110, c[20:18]};
    s[1] = {2'b10, c[17:12]};
    s[2] = {2'b10, c[11:6]};
    s[3] = {2'b10, c[5:0]};
    return 4;
  endfunction

  // Random well-formed multibyte sequence
  function automatic int rand_seq(output byte_t s [4]);
    int unsigned cp;
    case ($urandom_range(2, 4))
      2: cp = $urandom_range(32'h80, 32'h7FF);
      3: begin
        do cp = $urandom_range(32'h800, 32'hFFFF);
        while (cp >= 32'hD800 && cp <= 32'hDFFF);
      end
      default: cp = $urandom_range(32'h10000, 32'h10FFFF);
    endcase
    return encode_cp(cp[20:0], s);
  endfunction

  // Append one random unit to the string
  task automatic add_unit(input unit_kind_t kind);
    byte_t s [4];
    int    n;
    int    k;
    case (kind)
      UNIT_ASCII: str_bytes.push_back(byte_t'($urandom_range(0, 127)));
      UNIT_MULTI: begin
        n = rand_seq(s);
        for (int i = 0; i < n; i++) str_bytes.push_back(s[i]);
      end
      UNIT_SURROGATE: begin
        str_bytes.push_back(8'hED);
        str_bytes.push_back(byte_t'($urandom_range(8'hA0, 8'hBF)));
        str_bytes.push_back(byte_t'($urandom_range(8'h80, 8'hBF)));
      end
      UNIT_BROKEN: begin
        // Valid prefix cut short, then a byte that usually breaks it
        n = rand_seq(s);
        k = $urandom_range(1, n - 1);
        for (int i = 0; i < k; i++) str_bytes.push_back(s[i]);
        if ($urandom_range(0, 1) == 0) begin
          str_bytes.push_back(byte_t'($urandom_range(0, 127)));
        end else begin
          str_bytes.push_back(byte_t'($urandom_range(0, 255)));
        end
      end
      default: str_bytes.push_back(byte_t'($urandom_range(0, 255)));
    endcase
  endtask

  function automatic unit_kind_t pick_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return UNIT_ASCII;
    if (r < 65) return UNIT_MULTI;
    if (r < 72) return UNIT_SURROGATE;
    if (r < 88) return UNIT_BROKEN;
    return UNIT_NOISE;
  endfunction

  initial begin
    byte_t dir [24] = '{
      8'h41, 8'h00, 8'h7F,
      8'hC2, 8'h80,
      8'hE0, 8'hA0, 8'h80,
      8'hF4, 8'h8F, 8'hBF, 8'hBF,
      8'hC0, 8'hFF, 8'h80,
      8'hE0, 8'h80,
      8'hED, 8'hA0, 8'h80,
      8'hF0, 8'h8F,
      8'hE1, 8'h80
    };
    int    sent;
    byte_t s [4];
    int    n;
    int    k;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, valid forms, bad leads, limits, surrogate, truncation
    foreach (dir[i]) send_byte(dir[i], i == 23);

    // Random strings of mostly well-formed units
    sent = 0;
    while (sent < RAND_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      str_bytes.delete();
      repeat ($urandom_range(1, 6)) add_unit(pick_unit());
      if ($urandom_range(0, 4) == 0) begin
        n = rand_seq(s);
        k = $urandom_range(1, n - 1);
        for (int i = 0; i < k; i++) str_bytes.push_back(s[i]);
      end
      foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
      sent += str_bytes.size();
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Drain, then give the block time to show any stray output
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: utf8_repair_maximal_subpart.f
hw/rtl/u8r_pkg.sv
hw/rtl/utf8_repair_maximal_subpart.sv
hw/rtl/u8r_checker.sv
test/utf8_checker.sv
test/tb.sv
